// ----- hdl/nbm_pkg.sv -----
// Shared types, codes, table and helpers for the backprop momentum neuron.
package nbm_pkg;

   localparam int MAX_INPUTS = 16;
   localparam int IDX_W      = 4;

   // operation codes carried on the input channel
   localparam logic [2:0] OP_FWD    = 3'd0;
   localparam logic [2:0] OP_TARGET = 3'd1;
   localparam logic [2:0] OP_PAIR   = 3'd2;
   localparam logic [2:0] OP_UPDATE = 3'd3;
   localparam logic [2:0] OP_LOAD   = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_OUTPUT = 2'd0;
   localparam logic [1:0] KIND_GRAD   = 2'd1;
   localparam logic [1:0] KIND_WEIGHT = 2'd2;

   // register indexes
   localparam logic CSR_LEARNING_RATE = 1'b0;
   localparam logic CSR_MOMENTUM      = 1'b1;

   localparam logic [15:0] LR_RESET  = 16'd9830;
   localparam logic [15:0] MOM_RESET = 16'd32768;

   typedef logic signed [15:0] q412_type;

   // tanh at steps of 1/8 in Q4.12
   function automatic logic [12:0] tanh_tab(input logic [5:0] i);
      logic [12:0] t;
      case (i)
         6'd0:  t = 13'd0;    6'd1:  t = 13'd509;  6'd2:  t = 13'd1003; 6'd3:  t = 13'd1468;
         6'd4:  t = 13'd1893; 6'd5:  t = 13'd2272; 6'd6:  t = 13'd2602; 6'd7:  t = 13'd2883;
         6'd8:  t = 13'd3119; 6'd9:  t = 13'd3315; 6'd10: t = 13'd3475; 6'd11: t = 13'd3604;
         6'd12: t = 13'd3707; 6'd13: t = 13'd3790; 6'd14: t = 13'd3856; 6'd15: t = 13'd3908;
         6'd16: t = 13'd3949; 6'd17: t = 13'd3981; 6'd18: t = 13'd4006; 6'd19: t = 13'd4026;
         6'd20: t = 13'd4041; 6'd21: t = 13'd4053; 6'd22: t = 13'd4063; 6'd23: t = 13'd4070;
         6'd24: t = 13'd4076; 6'd25: t = 13'd4080; 6'd26: t = 13'd4084; 6'd27: t = 13'd4086;
         6'd28: t = 13'd4089; 6'd29: t = 13'd4090; 6'd30: t = 13'd4091; 6'd31: t = 13'd4092;
         default: t = 13'd4093;
      endcase
      return t;
   endfunction

   // clamp to the 16-bit signed range
   function automatic q412_type sat16(input logic signed [63:0] v);
      q412_type r;
      if (v > 64'sd32767) r = 16'sh7FFF;
      else if (v < -64'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

endpackage

// ----- hdl/neuron_backprop_momentum_unit.sv -----
// Top level: tanh neuron with weights, gradient and momentum weight update.
// One shared 34x20 signed multiplier under a small sequencer serves the forward, gradient
// and update paths; a result waits in the hand-off state while the output register is
// still full. Synchronous active-high reset clears control, accumulator, output, gradient
// and delta weights, restores rates.
module neuron_backprop_momentum_unit
   import nbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // index[3:0], value[19:4], gradient_in[35:20], zero fill
   input  logic [2:0]  req_tuser,   // op[2:0]
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // slot[3:0], result[19:4], zero fill
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // sequencer states
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_MAC  = 5'd1;   // element product
   localparam logic [4:0] S_ACC  = 5'd2;   // saturating accumulate
   localparam logic [4:0] S_TANH = 5'd3;   // table lookup, slope * fraction
   localparam logic [4:0] S_TFIN = 5'd4;
   localparam logic [4:0] S_DER  = 5'd5;   // y * y
   localparam logic [4:0] S_DERF = 5'd6;   // d = 1 - y*y
   localparam logic [4:0] S_GMUL = 5'd7;   // (target - y) * d
   localparam logic [4:0] S_GFIN = 5'd8;
   localparam logic [4:0] S_HLO  = 5'd9;   // low half of acc * d
   localparam logic [4:0] S_HHI  = 5'd10;  // high half of acc * d
   localparam logic [4:0] S_HFIN = 5'd11;
   localparam logic [4:0] S_U1   = 5'd12;  // eta * input
   localparam logic [4:0] S_U2   = 5'd13;  // * gradient
   localparam logic [4:0] S_U3   = 5'd14;  // alpha * old delta
   localparam logic [4:0] S_U4   = 5'd15;  // new delta
   localparam logic [4:0] S_U5   = 5'd16;  // new weight
   localparam logic [4:0] S_OUT  = 5'd17;  // hand result to the output register

   logic [4:0] state_ff, state_in;

   // latched item
   logic [2:0]        op_ff;
   logic [IDX_W-1:0]  idx_ff;
   q412_type          val_ff, gin_ff;
   logic              last_ff;

   // configuration
   logic [15:0] lr_ff, mom_ff;

   // neuron state
   q412_type          w_ff  [MAX_INPUTS];
   q412_type          dw_ff [MAX_INPUTS];
   q412_type          xin_ff[MAX_INPUTS];
   logic signed [39:0] acc_ff;
   q412_type          y_ff, grad_ff;

   // datapath registers
   logic signed [53:0] prod_ff;
   logic signed [63:0] sum_ff;
   logic signed [19:0] d_ff;
   logic [12:0]        tbase_ff;
   logic               neg_ff, big_ff;
   q412_type           nd_ff;

   // pending result and output register
   q412_type    res_ff;
   logic [1:0]  kind_ff;
   logic [3:0]  slot_ff;
   logic        rsp_valid_ff;
   q412_type    rsp_result_ff;
   logic [1:0]  rsp_kind_ff;
   logic [3:0]  rsp_slot_ff;
   logic        rsp_load;

   logic accept;
   logic idx_ok;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign idx_ok     = ({1'b0, idx_ff} < 5'(MAX_INPUTS));
   // move the pending result into the output register when it is free or being taken
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // shared multiplier, operands picked by state
   logic signed [33:0] mul_a;
   logic signed [19:0] mul_b;
   logic signed [53:0] prod_in;

   // tanh front end
   logic               acc_neg;
   logic [40:0]        acc_mag;
   logic [13:0]        mag_q;
   logic [5:0]         tab_i;
   logic signed [13:0] tab_slope;

   always_comb begin
      acc_neg   = acc_ff[39];
      acc_mag   = acc_neg ? 41'(-{acc_ff[39], acc_ff}) : {1'b0, acc_ff};
      mag_q     = acc_mag[25:12];
      tab_i     = {1'b0, mag_q[13:9]};
      tab_slope = 14'(signed'({1'b0, tanh_tab(tab_i + 6'd1)}))
                - 14'(signed'({1'b0, tanh_tab(tab_i)}));
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MAC: begin
            mul_a = 34'(val_ff);
            // keep a skipped forward element out of the sum
            if (op_ff == OP_FWD) mul_b = idx_ok ? 20'(w_ff[idx_ff]) : 20'sd0;
            else mul_b = 20'(gin_ff);
         end
         S_TANH: begin
            mul_a = 34'(tab_slope);
            mul_b = 20'(signed'({1'b0, mag_q[8:0]}));
         end
         S_DER: begin
            mul_a = 34'(y_ff);
            mul_b = 20'(y_ff);
         end
         S_GMUL: begin
            mul_a = 34'(17'(val_ff) - 17'(y_ff));
            mul_b = d_ff;
         end
         S_HLO: begin
            mul_a = 34'(signed'({1'b0, acc_ff[19:0]}));
            mul_b = d_ff;
         end
         S_HHI: begin
            mul_a = 34'(signed'(acc_ff[39:20]));
            mul_b = d_ff;
         end
         S_U1: begin
            mul_a = 34'(signed'({1'b0, lr_ff}));
            mul_b = 20'(xin_ff[idx_ff]);
         end
         S_U2: begin
            mul_a = prod_ff[33:0];
            mul_b = 20'(grad_ff);
         end
         S_U3: begin
            mul_a = 34'(signed'({1'b0, mom_ff}));
            mul_b = 20'(dw_ff[idx_ff]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // combinational finishing of each path
   logic signed [40:0] acc_sum;
   logic signed [39:0] acc_sat;
   logic signed [53:0] tanh_frac;
   logic signed [15:0] tanh_mag, tanh_y;
   logic signed [53:0] der_r;
   logic signed [53:0] g1_r;
   logic signed [63:0] h_total, u_total;
   logic signed [16:0] w_sum;

   always_comb begin
      acc_sum = 41'(acc_ff) + 41'(prod_ff);
      if (acc_sum[40] != acc_sum[39]) begin
         acc_sat = acc_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      end else begin
         acc_sat = acc_sum[39:0];
      end
      tanh_frac = (prod_ff + 54'sd256) >>> 9;
      tanh_mag  = big_ff ? 16'sd4096
                         : 16'(signed'({3'b000, tbase_ff})) + 16'(tanh_frac);
      tanh_y    = neg_ff ? -tanh_mag : tanh_mag;
      der_r     = (prod_ff + 54'sd2048) >>> 12;
      g1_r      = (prod_ff + 54'sd2048) >>> 12;
      h_total   = sum_ff + (64'(prod_ff) <<< 20);
      u_total   = sum_ff + (64'(prod_ff) <<< 12);
      w_sum     = 17'(w_ff[idx_ff]) + 17'(nd_ff);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_tuser) inside
                  OP_FWD, OP_PAIR: state_in = S_MAC;
                  OP_TARGET:       state_in = S_DER;
                  OP_UPDATE:       state_in = S_U1;
                  default:         state_in = S_IDLE;
               endcase
            end
         end
         S_MAC: state_in = S_ACC;
         S_ACC: begin
            if (!last_ff) state_in = S_IDLE;
            else if (op_ff == OP_FWD) state_in = S_TANH;
            else state_in = S_DER;
         end
         S_TANH: state_in = S_TFIN;
         S_TFIN: state_in = S_OUT;
         S_DER:  state_in = S_DERF;
         S_DERF: state_in = (op_ff == OP_TARGET) ? S_GMUL : S_HLO;
         S_GMUL: state_in = S_GFIN;
         S_GFIN: state_in = S_OUT;
         S_HLO:  state_in = S_HHI;
         S_HHI:  state_in = S_HFIN;
         S_HFIN: state_in = S_OUT;
         S_U1:   state_in = idx_ok ? S_U2 : S_IDLE;
         S_U2:   state_in = S_U3;
         S_U3:   state_in = S_U4;
         S_U4:   state_in = S_U5;
         S_U5:   state_in = S_OUT;
         S_OUT:  state_in = rsp_load ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lr_ff        <= LR_RESET;
         mom_ff       <= MOM_RESET;
         acc_ff       <= '0;
         y_ff         <= '0;
         grad_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_INPUTS; k++) begin
            dw_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         prod_ff  <= prod_in;

         if (csr_we) begin
            if (csr_index == CSR_LEARNING_RATE) lr_ff <= csr_wdata;
            else mom_ff <= csr_wdata;
         end

         // load the next result from the sequencer, drop the current one once taken
         if (rsp_load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_result_ff <= res_ff;
            rsp_kind_ff   <= kind_ff;
            rsp_slot_ff   <= slot_ff;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff  <= 1'b0;
         end

         if (accept) begin
            op_ff   <= req_tuser;
            idx_ff  <= req_tdata[3:0];
            val_ff  <= req_tdata[19:4];
            gin_ff  <= req_tdata[35:20];
            last_ff <= req_tlast;
            // weight load completes here
            if (req_tuser == OP_LOAD && ({1'b0, req_tdata[3:0]} < 5'(MAX_INPUTS))) begin
               w_ff[req_tdata[3:0]]  <= req_tdata[19:4];
               dw_ff[req_tdata[3:0]] <= '0;
            end
         end

         unique case (state_ff)
            S_MAC: begin
               if (op_ff == OP_FWD && idx_ok) xin_ff[idx_ff] <= val_ff;
            end
            S_ACC: acc_ff <= acc_sat;
            S_TANH: begin
               neg_ff   <= acc_neg;
               big_ff   <= (acc_mag >= 41'd67108864);
               tbase_ff <= tanh_tab(tab_i);
            end
            S_TFIN: begin
               y_ff    <= tanh_y;
               acc_ff  <= '0;
               res_ff  <= tanh_y;
               kind_ff <= KIND_OUTPUT;
               slot_ff <= '0;
            end
            S_DERF: d_ff <= 20'sd4096 - 20'(der_r);
            S_GFIN: begin
               grad_ff <= sat16(64'(g1_r));
               res_ff  <= sat16(64'(g1_r));
               kind_ff <= KIND_GRAD;
               slot_ff <= '0;
            end
            S_HHI: sum_ff <= 64'(prod_ff);
            S_HFIN: begin
               grad_ff <= sat16((h_total + 64'sd8388608) >>> 24);
               res_ff  <= sat16((h_total + 64'sd8388608) >>> 24);
               acc_ff  <= '0;
               kind_ff <= KIND_GRAD;
               slot_ff <= '0;
            end
            S_U3: sum_ff <= 64'(prod_ff);
            S_U4: begin
               nd_ff         <= sat16((u_total + 64'sd134217728) >>> 28);
               dw_ff[idx_ff] <= sat16((u_total + 64'sd134217728) >>> 28);
            end
            S_U5: begin
               w_ff[idx_ff] <= sat16(64'(w_sum));
               res_ff       <= sat16(64'(w_sum));
               kind_ff      <= KIND_WEIGHT;
               slot_ff      <= idx_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_result_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;

`ifndef SYNTHESIS
   // an item that starts the sequencer keeps the input closed next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_FWD || req_tuser == OP_TARGET ||
       req_tuser == OP_PAIR || req_tuser == OP_UPDATE)) |=> !req_tready)
      else $error("input accepted back to back");

   // a new result appears only from the hand-off state
   assert property (@(posedge clock) disable iff (reset)
      (!$past(rsp_valid_ff) && rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside hand-off");

   // the accumulator is cleared after a forward stream ends
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TFIN) |=> (acc_ff == 40'sd0))
      else $error("accumulator not cleared after tanh");

   // a weight result carries its slot, other kinds carry zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff != KIND_WEIGHT) |-> (rsp_slot_ff == 4'd0))
      else $error("nonzero slot on non-weight result");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the tanh neuron with backprop and momentum.
`timescale 1ns / 100ps

module tb
   import nbm_pkg::*;
();

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  index;
      logic [15:0] value;
      logic [15:0] gradient_in;
      logic        last;
   } neuron_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  slot;
      logic [15:0] result;
   } neuron_result_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [2:0] OP_SPARE = 3'd7;   // unused operation code

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // index[3:0], value[19:4], gradient_in[35:20], zero fill
   logic [2:0]  req_tuser;   // op[2:0]
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // slot[3:0], result[19:4], zero fill
   logic [1:0]  rsp_tuser;   // kind[1:0]
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   neuron_backprop_momentum_unit dut (.*);

   always begin
      clock = 1'b0; #6;
      clock = 1'b1; #6;
   end

   // ---------------------------------------------------------------
   // Predictor state: a private copy of the neuron
   // ---------------------------------------------------------------
   int tanh_points [33] = '{
      0, 509, 1003, 1468, 1893, 2272, 2602, 2883,
      3119, 3315, 3475, 3604, 3707, 3790, 3856, 3908,
      3949, 3981, 4006, 4026, 4041, 4053, 4063, 4070,
      4076, 4080, 4084, 4086, 4089, 4090, 4091, 4092, 4093};

   longint eta, alpha;
   longint wt [16] = '{default: 0};
   longint dwt [16] = '{default: 0};
   longint xin [16] = '{default: 0};
   longint acc_sum = 0;
   longint y_out = 0;
   longint grad = 0;

   neuron_item_type   pending_items [$];
   neuron_result_type expected_results [$];
   int  error_count = 0;
   bit  tail_quiet = 0;     // no idling in the last part of the run
   bit  hold_sender = 0;

   // Stimulus-side view of which entries have been written.
   bit wt_written_q [16];
   bit xin_written_q [16];

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // floor((v + 2^(s-1)) / 2^s)
   function automatic longint round_sh(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic void acc_accumulate(longint p);
      longint hi, t;
      hi = (longint'(1) <<< 39) - 1;
      t = acc_sum + p;
      if (t > hi) t = hi;
      if (t < -hi - 1) t = -hi - 1;
      acc_sum = t;
   endfunction

   function automatic longint tanh_of_sum(longint a);
      longint mag, m, y, d, f;
      int i;
      mag = (a < 0) ? -a : a;
      if (mag >= (longint'(4) <<< 24)) y = 4096;
      else begin
         m = mag >>> 12;
         i = int'((m >>> 9) & 31);
         f = m & 511;
         d = tanh_points[i + 1] - tanh_points[i];
         y = tanh_points[i] + ((d * f + 256) >>> 9);
      end
      return (a < 0) ? -y : y;
   endfunction

   function automatic longint slope_of_output();
      return 4096 - round_sh(y_out * y_out, 12);
   endfunction

   function automatic void push_result(logic [1:0] kind, logic [3:0] slot, longint r);
      neuron_result_type e;
      e.kind = kind; e.slot = slot; e.result = r[15:0];
      expected_results = {expected_results, e};
   endfunction

   // Advance the predictor by one accepted item.
   function automatic void predict_neuron(neuron_item_type it);
      longint v, g, a, b, nd;
      v = longint'($signed(it.value));
      g = longint'($signed(it.gradient_in));
      case (it.op)
         OP_FWD: begin
            xin[it.index] = v;
            acc_accumulate(v * wt[it.index]);
            if (it.last) begin
               y_out = tanh_of_sum(acc_sum);
               acc_sum = 0;
               push_result(KIND_OUTPUT, 4'd0, y_out);
            end
         end
         OP_TARGET: begin
            grad = clamp16(round_sh((v - y_out) * slope_of_output(), 12));
            push_result(KIND_GRAD, 4'd0, grad);
         end
         OP_PAIR: begin
            acc_accumulate(v * g);
            if (it.last) begin
               grad = clamp16(round_sh(acc_sum * slope_of_output(), 24));
               acc_sum = 0;
               push_result(KIND_GRAD, 4'd0, grad);
            end
         end
         OP_UPDATE: begin
            a = eta * xin[it.index] * grad;
            b = (alpha * dwt[it.index]) * 4096;
            nd = clamp16(round_sh(a + b, 28));
            dwt[it.index] = nd;
            wt[it.index] = clamp16(wt[it.index] + nd);
            push_result(KIND_WEIGHT, it.index, wt[it.index]);
         end
         OP_LOAD: begin
            wt[it.index] = v;
            dwt[it.index] = 0;
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------
   function automatic void queue_item(logic [2:0] op, logic [3:0] index, logic [15:0] value,
                                      logic [15:0] gin, logic last);
      neuron_item_type it;
      it.op = op; it.index = index; it.value = value; it.gradient_in = gin; it.last = last;
      pending_items = {pending_items, it};
   endfunction

   function automatic logic [15:0] rand_q();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 8191) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   // Issue one well-formed training step over inputs 0..n-1.
   function automatic void queue_training_step(int n);
      int k;
      for (k = 0; k < n; k++)
         queue_item(OP_FWD, 4'(k), rand_q(), 16'($urandom), k == n - 1);
      if ($urandom_range(0, 1)) queue_item(OP_TARGET, 4'($urandom), rand_q(),
                                           16'($urandom), 1'($urandom));
      else begin
         k = $urandom_range(1, 4);
         repeat (k - 1) queue_item(OP_PAIR, 4'($urandom), rand_q(), rand_q(), 1'b0);
         queue_item(OP_PAIR, 4'($urandom), rand_q(), rand_q(), 1'b1);
      end
      for (k = 0; k < n; k++)
         if ($urandom_range(0, 3) != 0)
            queue_item(OP_UPDATE, 4'(k), 16'($urandom), 16'($urandom), 1'($urandom));
   endfunction

   // Noise: random items, keeping away from entries never written.
   function automatic void queue_noise();
      logic [2:0] op;
      logic [3:0] ix;
      op = 3'($urandom_range(0, 7));
      ix = 4'($urandom);
      if (op == OP_FWD && !wt_written_q[ix]) op = OP_LOAD;
      if (op == OP_UPDATE && !(wt_written_q[ix] && xin_written_q[ix])) op = OP_LOAD;
      if (op == OP_LOAD) wt_written_q[ix] = 1;
      if (op == OP_FWD) xin_written_q[ix] = 1;
      queue_item(op, ix, rand_q(), rand_q(), 1'($urandom));
   endfunction

   // ---------------------------------------------------------------
   // Driver
   // ---------------------------------------------------------------
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         req_tlast  <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
         // hold the item until accepted
      end else begin
         if (req_tvalid && req_tready) predict_neuron(pending_items.pop_front());
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 19) - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() != 0 && !hold_sender) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_items[0].op;
            req_tlast  <= pending_items[0].last;
            req_tdata  <= {4'd0, pending_items[0].gradient_in, pending_items[0].value,
                           pending_items[0].index};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor and back-pressure
   // ---------------------------------------------------------------
   int stall_left = 0;
   always @(posedge clock) begin
      neuron_result_type got, exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser; got.slot = rsp_tdata[3:0]; got.result = rsp_tdata[19:4];
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result kind=%0d slot=%0d result=%0d", $time,
                        got.kind, got.slot, $signed(got.result));
               error_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (got !== exp_r || rsp_tdata[23:20] !== 4'd0) begin
                  $display({"%0t: mismatch expected kind=%0d slot=%0d result=%0d,",
                            " actual kind=%0d slot=%0d result=%0d"},
                           $time, exp_r.kind, exp_r.slot, $signed(exp_r.result),
                           got.kind, got.slot, $signed(got.result));
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 19) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Cycle counter: stop on a hung run.
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Sequencing
   // ---------------------------------------------------------------
   task automatic drain();
      while (pending_items.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      // let a result-free item (load or non-last element) finish
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] data);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LEARNING_RATE) eta = data; else alpha = data;
   endtask

   initial begin
      int k, phase;
      reset = 1'b1;
      csr_we = 1'b0; csr_index = 1'b0; csr_wdata = '0;
      eta = LR_RESET; alpha = MOM_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: load every weight, including the extremes.
      for (k = 0; k < 16; k++) begin
         queue_item(OP_LOAD, 4'(k), (k == 0) ? 16'h7FFF : (k == 1) ? 16'h8000 : rand_q(),
                    16'hFFFF, k[0]);
         wt_written_q[k] = 1;
      end
      // Drive the tanh into saturation: full-scale inputs against full-scale weights.
      queue_item(OP_FWD, 0, 16'h7FFF, 16'h0, 1'b0);
      queue_item(OP_FWD, 1, 16'h8000, 16'h0, 1'b1);
      // Target extremes and a stray last mark.
      queue_item(OP_TARGET, 0, 16'h8000, 16'h0, 1'b1);
      queue_item(OP_UPDATE, 0, 16'h0, 16'h0, 1'b1);
      // Downstream pairs at full scale, then an unused op.
      queue_item(OP_PAIR, 0, 16'h8000, 16'h8000, 1'b0);
      queue_item(OP_PAIR, 0, 16'h8000, 16'h8000, 1'b1);
      queue_item(OP_SPARE, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1);
      queue_item(OP_UPDATE, 1, 16'h0, 16'h0, 1'b0);
      for (k = 0; k < 2; k++) begin
         xin_written_q[k] = 1;
      end
      // Interleaved forward and pair streams share the accumulator.
      queue_item(OP_FWD, 2, 16'h1000, 16'h0, 1'b0);
      queue_item(OP_PAIR, 0, 16'h1000, 16'h1000, 1'b1);
      queue_item(OP_FWD, 2, 16'h0800, 16'h0, 1'b1);
      xin_written_q[2] = 1;
      queue_item(OP_TARGET, 0, 16'h7FFF, 16'h0, 1'b0);
      queue_item(OP_UPDATE, 2, 16'h0, 16'h0, 1'b0);
      drain();

      // Random phases, each with its own register setting.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_LEARNING_RATE, 16'hFFFF);
               write_csr(CSR_MOMENTUM, 16'hFFFF);
            end
            1: begin
               write_csr(CSR_LEARNING_RATE, 16'h0000);
               write_csr(CSR_MOMENTUM, 16'h0000);
            end
            default: begin
               write_csr(CSR_LEARNING_RATE, 16'($urandom));
               write_csr(CSR_MOMENTUM, 16'($urandom));
            end
         endcase
         while (pending_items.size() < 180) begin
            if ($urandom_range(0, 4) == 0) queue_noise();
            else begin
               k = $urandom_range(2, 16);
               for (int j = 0; j < k; j++) begin
                  if (!wt_written_q[j] || $urandom_range(0, 7) == 0)
                     queue_item(OP_LOAD, 4'(j), rand_q(), 16'($urandom), 1'($urandom));
                  wt_written_q[j] = 1; xin_written_q[j] = 1;
               end
               queue_training_step(k);
            end
         end
         if (phase == 5) tail_quiet = 1;
         if (phase == 2) begin
            // pause the sender until the block has caught up
            while (pending_items.size() > 90) @(posedge clock);
            hold_sender = 1;
            while (req_tvalid || expected_results.size() != 0) @(posedge clock);
            hold_sender = 0;
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule
